// ----- design/mip_chain_byte_count_defines.svh -----
// Assertion macros for the mip chain byte count block.
// Used by the top level; needs clk and rst_n in the scope of each use.
`ifndef MIP_CHAIN_BYTE_COUNT_DEFINES_SVH
`define MIP_CHAIN_BYTE_COUNT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MCBC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define MCBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/mcbc_pkg.sv -----
// Shared types, constants and format table for the mip chain byte count block.
// No dependencies.
package mcbc_pkg;

  localparam int DIM_BITS_DEF = 14;
  localparam int IN_DIM_W     = 15;
  localparam int FMT_W        = 4;
  localparam int LVL_W        = 4;
  localparam int TOTAL_W      = 47;
  localparam int BYTES_W      = 5;

  typedef enum logic [1:0] {
    TEX_1D     = 2'd0,
    TEX_2D     = 2'd1,
    TEX_VOLUME = 2'd2,
    TEX_CUBE   = 2'd3
  } tex_type_t;

  typedef enum logic [FMT_W-1:0] {
    FMT_BGR_U8    = 4'd0,
    FMT_BGRA_U8   = 4'd1,
    FMT_RGBA_F16  = 4'd2,
    FMT_RGBA_F32  = 4'd3,
    FMT_UNUSED_A  = 4'd4,
    FMT_DXT1      = 4'd5,
    FMT_DXT3      = 4'd6,
    FMT_DXT5      = 4'd7,
    FMT_UNUSED_B  = 4'd8,
    FMT_R_F32     = 4'd9,
    FMT_BGRA_5551 = 4'd10,
    FMT_A_U8      = 4'd11,
    FMT_RGBA_U8   = 4'd12,
    FMT_INVALID   = 4'd13
  } fmt_code_t;

  typedef struct packed {
    logic               dxt;    // 4x4 block footprint
    logic [BYTES_W-1:0] bytes;  // bytes per block
  } fmt_info_t;

  typedef struct packed {
    logic load;    // capture request fields
    logic setup;   // apply type rules, level count, clear sum
    logic issue;   // push one mip level into the pipe
    logic finish;  // face multiply into the output register
  } mcbc_cmd_t;

  typedef struct packed {
    logic lvl_last;    // current level is the last one
    logic pipe_empty;  // no level left in the multiply pipe
  } mcbc_sts_t;

  function automatic fmt_info_t fmt_info(input logic [FMT_W-1:0] code);
    fmt_info_t r;
    case (fmt_code_t'(code))
      FMT_BGR_U8:    r = '{dxt: 1'b0, bytes: 5'd3};
      FMT_BGRA_U8:   r = '{dxt: 1'b0, bytes: 5'd4};
      FMT_RGBA_F16:  r = '{dxt: 1'b0, bytes: 5'd8};
      FMT_RGBA_F32:  r = '{dxt: 1'b0, bytes: 5'd16};
      FMT_UNUSED_A:  r = '{dxt: 1'b0, bytes: 5'd1};
      FMT_DXT1:      r = '{dxt: 1'b1, bytes: 5'd8};
      FMT_DXT3:      r = '{dxt: 1'b1, bytes: 5'd16};
      FMT_DXT5:      r = '{dxt: 1'b1, bytes: 5'd16};
      FMT_UNUSED_B:  r = '{dxt: 1'b0, bytes: 5'd4};
      FMT_R_F32:     r = '{dxt: 1'b0, bytes: 5'd4};
      FMT_BGRA_5551: r = '{dxt: 1'b0, bytes: 5'd2};
      FMT_A_U8:      r = '{dxt: 1'b0, bytes: 5'd1};
      FMT_RGBA_U8:   r = '{dxt: 1'b0, bytes: 5'd4};
      default:       r = '{dxt: 1'b0, bytes: 5'd0};  // invalid and above
    endcase
    return r;
  endfunction

  // floor(log2(v)), 0 for v of 0 or 1
  function automatic logic [LVL_W-1:0] flog2(input logic [IN_DIM_W-1:0] v);
    logic [LVL_W-1:0] n;
    n = '0;
    for (int i = 1; i < IN_DIM_W; i++) begin
      if (v[i]) n = LVL_W'(i);
    end
    return n;
  endfunction

endpackage

// ----- design/mcbc_ctrl.sv -----
// Controller for the mip chain byte count block: sequences load, setup,
// level issue, pipe drain and output. Uses mcbc_pkg.
module mcbc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  mcbc_pkg::mcbc_sts_t sts,
  output mcbc_pkg::mcbc_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN,
    ST_DRAIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        if (sts.lvl_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (sts.pipe_empty && out_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- design/mcbc_dp.sv -----
// Datapath for the mip chain byte count block: request registers, level
// walker, two-stage multiply pipe, accumulator and face multiply. Uses mcbc_pkg.
module mcbc_dp #(
  parameter int DIM_BITS = mcbc_pkg::DIM_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mcbc_pkg::mcbc_cmd_t                cmd,
  output mcbc_pkg::mcbc_sts_t                sts,
  input  logic [1:0]                         in_texture_type,
  input  logic [mcbc_pkg::FMT_W-1:0]         in_pixel_format,
  input  logic [mcbc_pkg::IN_DIM_W-1:0]      in_size_x,
  input  logic [mcbc_pkg::IN_DIM_W-1:0]      in_size_y,
  input  logic [mcbc_pkg::IN_DIM_W-1:0]      in_size_z,
  input  logic [mcbc_pkg::LVL_W-1:0]         in_level_request,
  output logic [mcbc_pkg::TOTAL_W-1:0]       out_total_bytes
);

  localparam int DW  = (DIM_BITS + 1 < mcbc_pkg::IN_DIM_W) ? DIM_BITS + 1
                                                           : mcbc_pkg::IN_DIM_W;
  localparam int LIM = 1 << DIM_BITS;
  localparam int BBW = DW + mcbc_pkg::BYTES_W;
  localparam int PW  = 2 * DW + BBW;
  localparam int AW  = mcbc_pkg::TOTAL_W;
  localparam int LW  = mcbc_pkg::LVL_W;

  function automatic logic [DW-1:0] sat_dim(input logic [mcbc_pkg::IN_DIM_W-1:0] v);
    logic [16:0] lim;
    lim = 17'(LIM);
    if ({2'b00, v} > lim) return DW'(lim);
    return DW'(v);
  endfunction

  mcbc_pkg::tex_type_t    type_r;
  mcbc_pkg::fmt_info_t    fmt_in, fmt_r;
  logic [DW-1:0]          sx_r, sy_r, sz_r;
  logic [LW-1:0]          req_r;
  logic [DW-1:0]          w_r, h_r, d_r;
  logic [LW-1:0]          lvl_r;
  logic                   cube_r;
  logic                   s1_v_r, s2_v_r;
  logic [2*DW-1:0]        bxd_r;
  logic [BBW-1:0]         bb_r;
  logic [AW-1:0]          prod_r, acc_r, out_total_r;

  // setup terms
  logic [DW-1:0]          m_xy, m_all;
  logic [LW-1:0]          full_lvl;
  // level terms
  logic [DW:0]            wp3, hp3;
  logic [DW-1:0]          bx, by;
  logic [PW-1:0]          prod_full;
  logic [AW-1:0]          acc6;

  assign fmt_in = mcbc_pkg::fmt_info(in_pixel_format);

  assign m_xy     = (sx_r > sy_r) ? sx_r : sy_r;
  assign m_all    = (sz_r > m_xy) ? sz_r : m_xy;
  assign full_lvl = LW'(mcbc_pkg::flog2(mcbc_pkg::IN_DIM_W'(m_all)) + 1'b1);

  // ceil-div by the block footprint
  assign wp3 = {1'b0, w_r} + (DW+1)'(3);
  assign hp3 = {1'b0, h_r} + (DW+1)'(3);
  assign bx  = fmt_r.dxt ? DW'(wp3 >> 2) : w_r;
  assign by  = fmt_r.dxt ? DW'(hp3 >> 2) : h_r;

  assign prod_full = PW'(bxd_r) * PW'(bb_r);
  assign acc6      = (acc_r << 2) + (acc_r << 1);

  assign sts.lvl_last   = (lvl_r == LW'(1));
  assign sts.pipe_empty = !s1_v_r && !s2_v_r;
  assign out_total_bytes = out_total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.issue;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      type_r <= mcbc_pkg::tex_type_t'(in_texture_type);
      fmt_r  <= fmt_in;
      sx_r   <= sat_dim(in_size_x);
      sy_r   <= sat_dim(in_size_y);
      sz_r   <= sat_dim(in_size_z);
      req_r  <= in_level_request;
    end

    if (cmd.setup) begin
      w_r    <= sx_r;
      h_r    <= (type_r == mcbc_pkg::TEX_1D) ? DW'(1) : sy_r;
      d_r    <= (type_r == mcbc_pkg::TEX_VOLUME) ? sz_r : DW'(1);
      cube_r <= (type_r == mcbc_pkg::TEX_CUBE);
      lvl_r  <= (req_r == '0 || req_r > full_lvl) ? full_lvl : req_r;
    end else if (cmd.issue) begin
      w_r   <= ((w_r >> 1) == '0) ? DW'(1) : (w_r >> 1);
      h_r   <= ((h_r >> 1) == '0) ? DW'(1) : (h_r >> 1);
      d_r   <= ((d_r >> 1) == '0) ? DW'(1) : (d_r >> 1);
      lvl_r <= lvl_r - LW'(1);
    end

    // stage 1: blocks across times depth, blocks down times block bytes
    bxd_r <= (2*DW)'(bx) * (2*DW)'(d_r);
    bb_r  <= BBW'(by) * BBW'(fmt_r.bytes);

    // stage 2: level bytes, wrapped to the output width
    prod_r <= AW'(prod_full);

    if (cmd.setup) begin
      acc_r <= '0;
    end else if (s2_v_r) begin
      acc_r <= acc_r + prod_r;
    end

    if (cmd.finish) begin
      out_total_r <= cube_r ? acc6 : acc_r;
    end
  end

endmodule

// ----- design/mip_chain_byte_count.sv -----
// Top level of the mip chain byte count block.
// Instantiates mcbc_ctrl and mcbc_dp; uses mcbc_pkg and the assertion header.

// Mip chain byte count. One request beat in, one total_bytes beat out. The
// request is taken only while the block is idle; a finished total waits in
// the output register and does not hold off the next request. After the
// capture edge the block runs setup, then for each of the L levels (the
// requested count, or the full chain of floor(log2(max dim)) + 1 levels,
// at most 15) the level walker pushes one mip level per cycle into the
// two-stage multiply pipe; the pipe drains, and the face multiply loads
// the output register. Only then does the block go idle and take a new
// request. The output stage waits while an earlier total is still stalled.
// Dimensions saturate at 2^DIM_BITS; totals wrap at 47 bits.
`include "mip_chain_byte_count_defines.svh"

module mip_chain_byte_count #(
  parameter int DIM_BITS = mcbc_pkg::DIM_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_texture_type,
  input  logic [mcbc_pkg::FMT_W-1:0]    in_pixel_format,
  input  logic [mcbc_pkg::IN_DIM_W-1:0] in_size_x,
  input  logic [mcbc_pkg::IN_DIM_W-1:0] in_size_y,
  input  logic [mcbc_pkg::IN_DIM_W-1:0] in_size_z,
  input  logic [mcbc_pkg::LVL_W-1:0]    in_level_request,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mcbc_pkg::TOTAL_W-1:0]  out_total_bytes
);

  mcbc_pkg::mcbc_cmd_t cmd;  // controller to datapath
  mcbc_pkg::mcbc_sts_t sts;  // datapath to controller

  mcbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mcbc_dp #(
    .DIM_BITS (DIM_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_texture_type  (in_texture_type),
    .in_pixel_format  (in_pixel_format),
    .in_size_x        (in_size_x),
    .in_size_y        (in_size_y),
    .in_size_z        (in_size_z),
    .in_level_request (in_level_request),
    .out_total_bytes  (out_total_bytes)
  );

  function automatic logic s_busy_cmd(input mcbc_pkg::mcbc_cmd_t c);
    return c.setup || c.finish;
  endfunction

  // an accepted beat makes the block busy in the next cycle
  `MCBC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "no busy after accept")
  // the total is taken only after every level has left the pipe
  `MCBC_ASSERT_NOW(a_finish_pipe_empty, cmd.finish, sts.pipe_empty, "finish with levels in pipe")
  // finishing presents a result in the next cycle
  `MCBC_ASSERT_NEXT(a_finish_shows_out, cmd.finish, out_valid, "finish without out_valid")
  // no level is issued while a request is being captured
  `MCBC_ASSERT_NOW(a_no_issue_on_load, cmd.load, !cmd.issue && !s_busy_cmd(cmd), "issue on load")

endmodule

// ----- tb/sv/tb_mip_chain_byte_count.sv -----
// Self-checking testbench for mip_chain_byte_count: random and directed requests,
// predicted totals held in a small scoreboard class. Depends on mcbc_pkg and the DUT.
`timescale 1ns / 100ps

module tb_mip_chain_byte_count;
  import mcbc_pkg::*;

  // One request beat as the driver sees it. The format stays a raw code so that
  // the two codes above the invalid entry can be sent too.
  typedef struct {
    tex_type_t          ty;
    logic [FMT_W-1:0]   fmt;
    logic [IN_DIM_W-1:0] sx;
    logic [IN_DIM_W-1:0] sy;
    logic [IN_DIM_W-1:0] sz;
    logic [LVL_W-1:0]   lv;
  } mip_request_t;

  typedef struct {
    mip_request_t       req;
    logic [TOTAL_W-1:0] total;
  } chain_total_t;

  // Predicts the chain size of every accepted request and checks the totals
  // in order. Results come back in request order, one per request.
  class chain_size_board;
    chain_total_t pending[$];
    int unsigned  noted;
    int unsigned  checked;
    int unsigned  failures;

    // dimensions saturate at 2^DIM_BITS before anything else
    function int unsigned clamp_dim(logic [IN_DIM_W-1:0] v);
      int unsigned lim;
      lim = 1 << DIM_BITS_DEF;
      return (v > lim) ? lim : int'(v);
    endfunction

    function logic [TOTAL_W-1:0] chain_bytes(mip_request_t r);
      int unsigned w, h, d, top, full, lvls, faces, unit, bx, by;
      bit          dxt;
      logic [63:0] sum;
      w = clamp_dim(r.sx);
      h = clamp_dim(r.sy);
      d = clamp_dim(r.sz);
      faces = 1;
      case (r.fmt)
        FMT_BGR_U8:    unit = 3;
        FMT_BGRA_U8:   unit = 4;
        FMT_RGBA_F16:  unit = 8;
        FMT_RGBA_F32:  unit = 16;
        FMT_UNUSED_A:  unit = 1;
        FMT_DXT1:      unit = 8;
        FMT_DXT3:      unit = 16;
        FMT_DXT5:      unit = 16;
        FMT_UNUSED_B:  unit = 4;
        FMT_R_F32:     unit = 4;
        FMT_BGRA_5551: unit = 2;
        FMT_A_U8:      unit = 1;
        FMT_RGBA_U8:   unit = 4;
        default:       unit = 0;  // invalid, and every code past it
      endcase
      dxt = (r.fmt == FMT_DXT1) || (r.fmt == FMT_DXT3) || (r.fmt == FMT_DXT5);
      // full level count over the raw (saturated) sizes, before type rules
      top = (w > h) ? w : h;
      if (d > top) top = d;
      full = 1;
      while (top > 1) begin
        top = top >> 1;
        full++;
      end
      case (r.ty)
        TEX_1D: begin
          h = 1;
          d = 1;
        end
        TEX_2D: d = 1;
        TEX_CUBE: begin
          faces = 6;
          d = 1;
        end
        default: ;
      endcase
      lvls = (r.lv == 0 || r.lv > full) ? full : int'(r.lv);
      sum = '0;
      repeat (lvls) begin
        bx = dxt ? (w + 3) >> 2 : w;
        by = dxt ? (h + 3) >> 2 : h;
        sum += 64'(bx) * 64'(by) * 64'(unit) * 64'(d);
        w = (w > 1) ? w >> 1 : 1;
        h = (h > 1) ? h >> 1 : 1;
        d = (d > 1) ? d >> 1 : 1;
      end
      return TOTAL_W'(sum * 64'(faces));
    endfunction

    function void note_request(mip_request_t r);
      chain_total_t e;
      e.req   = r;
      e.total = chain_bytes(r);
      pending.push_back(e);
      noted++;
    endfunction

    function void check_total(logic [TOTAL_W-1:0] got);
      chain_total_t e;
      checked++;
      if (pending.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected total beat: %0d", got);
        return;
      end
      e = pending.pop_front();
      if (got !== e.total) begin
        failures++;
        if (failures <= 10)
          $display("total mismatch: type %0d fmt %0d size %0dx%0dx%0d lv %0d: exp %0d got %0d",
                   e.req.ty, e.req.fmt, e.req.sx, e.req.sy, e.req.sz, e.req.lv,
                   e.total, got);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           in_texture_type;
  logic [FMT_W-1:0]     in_pixel_format;
  logic [IN_DIM_W-1:0]  in_size_x;
  logic [IN_DIM_W-1:0]  in_size_y;
  logic [IN_DIM_W-1:0]  in_size_z;
  logic [LVL_W-1:0]     in_level_request;
  logic                 out_valid;
  logic                 out_stall;
  logic [TOTAL_W-1:0]   out_total_bytes;

  chain_size_board board;

  // Idle switches for each side, flipped per phase so that some stretches run
  // with back-to-back beats on both ends.
  bit send_idle;
  bit recv_idle;
  // Set by the main sequence to make the receiver hold off for this many cycles
  // on its next beat; the receiver clears it when it takes it.
  int unsigned hold_cycles;

  mip_chain_byte_count DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_texture_type (in_texture_type),
    .in_pixel_format (in_pixel_format),
    .in_size_x       (in_size_x),
    .in_size_y       (in_size_y),
    .in_size_z       (in_size_z),
    .in_level_request(in_level_request),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_total_bytes (out_total_bytes)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard stop, at more than six times the slowest legal run: about 730 beats,
  // each with the longest send gap, block run and receive stall, plus one
  // long hold.
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic mip_request_t req_of(tex_type_t ty, logic [FMT_W-1:0] fmt,
                                          int unsigned x, int unsigned y,
                                          int unsigned z, logic [LVL_W-1:0] lv);
    mip_request_t r;
    r.ty  = ty;
    r.fmt = fmt;
    r.sx  = IN_DIM_W'(x);
    r.sy  = IN_DIM_W'(y);
    r.sz  = IN_DIM_W'(z);
    r.lv  = lv;
    return r;
  endfunction

  // Mostly small sizes, with a share of full-range codes, exact powers of two,
  // values around the saturation point and the zero dimension.
  function automatic int unsigned rand_dim();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2, 3: return $urandom_range(1, 64);
      4, 5:       return $urandom_range(1, 16384);
      6:          return $urandom_range(0, 32767);
      7:          return 1 << $urandom_range(0, 14);
      8:          return $urandom_range(16380, 16390);
      default:    return ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(16385, 32767);
    endcase
  endfunction

  function automatic mip_request_t rand_request();
    return req_of(tex_type_t'($urandom_range(0, 3)), FMT_W'($urandom_range(0, 15)),
                  rand_dim(), rand_dim(), rand_dim(), LVL_W'($urandom_range(0, 15)));
  endfunction

  function automatic int unsigned send_gap();
    return send_idle ? $urandom_range(0, 10) : 0;
  endfunction

  // Offer one request beat and wait until the block takes it. Called at a
  // rising edge; returns at the edge that accepted the beat with valid still
  // high, so a zero gap keeps valid up across consecutive beats.
  task automatic send_request(input mip_request_t r, input int unsigned gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_texture_type  <= r.ty;
    in_pixel_format  <= r.fmt;
    in_size_x        <= r.sx;
    in_size_y        <= r.sy;
    in_size_z        <= r.sz;
    in_level_request <= r.lv;
    do @(posedge clk); while (in_stall);
    board.note_request(r);
  endtask

  // Drop valid and wait for every outstanding total to come back.
  task automatic drain_totals();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // Receiver: per beat it draws a stall stretch, or takes the long hold that
  // the main sequence asked for, then waits for a total and checks it.
  initial begin
    int unsigned n;
    out_stall <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
      end else begin
        n = recv_idle ? $urandom_range(0, 10) : 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
      board.check_total(out_total_bytes);
    end
  end

  initial begin
    board = new;
    send_idle   = 1'b1;
    recv_idle   = 1'b1;
    hold_cycles = 0;
    // every input known from time zero
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_texture_type  <= TEX_1D;
    in_pixel_format  <= FMT_BGR_U8;
    in_size_x        <= '0;
    in_size_y        <= '0;
    in_size_z        <= '0;
    in_level_request <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every format code (the two past the invalid entry too), each
    // type in turn, at an odd size that exercises the 4x4 rounding.
    for (int f = 0; f < 16; f++)
      send_request(req_of(tex_type_t'(f % 4), FMT_W'(f), 37 + f, 23, 5, '0), send_gap());
    // largest volume and cube map, widest format, full chain
    send_request(req_of(TEX_VOLUME, FMT_RGBA_F32, 16384, 16384, 16384, '0), send_gap());
    send_request(req_of(TEX_CUBE, FMT_RGBA_F32, 16384, 16384, 16384, '0), send_gap());
    // compressed 1D: height forced to 1 still rounds up to one block row
    send_request(req_of(TEX_1D, FMT_DXT5, 16384, 9, 9, '0), send_gap());
    // sizes above range saturate; a level request of all ones is exactly the full chain
    send_request(req_of(TEX_VOLUME, FMT_RGBA_F32, 32767, 32767, 32767, 4'hF), send_gap());
    // zero dimensions: first level adds nothing, later levels use 1
    send_request(req_of(TEX_VOLUME, FMT_BGR_U8, 0, 0, 0, '0), send_gap());
    send_request(req_of(TEX_2D, FMT_DXT1, 0, 9, 3, 4'd2), send_gap());
    send_request(req_of(TEX_2D, FMT_BGRA_U8, 1, 1, 1, '0), send_gap());
    // level count past the chain, exactly the chain, and a single level
    send_request(req_of(TEX_2D, FMT_RGBA_U8, 64, 64, 1, 4'd15), send_gap());
    send_request(req_of(TEX_2D, FMT_RGBA_U8, 64, 64, 1, 4'd7), send_gap());
    send_request(req_of(TEX_2D, FMT_RGBA_U8, 64, 64, 1, 4'd1), send_gap());
    // depth sets the chain length of a 2D texture though it is forced to 1
    send_request(req_of(TEX_2D, FMT_A_U8, 8, 8, 16384, '0), send_gap());
    drain_totals();

    // Random phases: both sides idling, neither, sender only, receiver only.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 0) || (ph == 2);
      recv_idle = (ph == 0) || (ph == 3);
      repeat (170) send_request(rand_request(), send_gap());
      drain_totals();
    end

    // Back pressure: receiver holds off for a long stretch while the sender
    // keeps offering beats, so the block fills up and stalls its input.
    send_idle   = 1'b0;
    recv_idle   = 1'b0;
    hold_cycles = 400;
    repeat (20) send_request(rand_request(), 0);
    drain_totals();

    // allow a stray extra total to show up before judging
    repeat (40) @(posedge clk);
    $display("Sent %0d requests over all types, all 16 format codes and all level counts,",
             board.noted);
    $display("with idle, back-to-back and long-hold phases; %0d totals checked, %0d failures.",
             board.checked, board.failures);
    if (board.failures == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
